[rtl/mmnst_pkg.sv]
// Shared types and constants for the min-max normalising score table.
package mmnst_pkg;

   // Fraction bits of the fixed-point score format.
   localparam int FRAC_BITS = 16;
   // Width of the table key field.
   localparam int KEY_BITS = 6;
   // Width of the value returned by a read.
   localparam int RSP_BITS = 32;

   typedef enum logic [2:0] {
      CMD_INSERT       = 3'd0,
      CMD_INSERT_WORST = 3'd1,
      CMD_CLEAR        = 3'd2,
      CMD_NORMALIZE    = 3'd3,
      CMD_READ         = 3'd4
   } cmd_type;

   // Control handed from the sequencer to the shared divider.
   typedef struct packed {
      logic start;
      logic negative;
   } div_ctrl_type;

endpackage

[rtl/mmnst_divider.sv]
// Iterative restoring divider giving a saturated signed fixed-point quotient.
module mmnst_divider
   import mmnst_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctrl_type          ctrl,
   input  logic [VALUE_BITS-1:0] numerator,
   input  logic [VALUE_BITS-1:0] denominator,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient
);

   localparam int QUO_BITS = VALUE_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(QUO_BITS + 1);
   localparam logic [VALUE_BITS-1:0] VAL_MAXPOS = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] VAL_MINNEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic                  run_ff;
   logic                  fin_ff;
   logic                  done_ff;
   logic                  neg_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [VALUE_BITS-1:0] rem_ff;
   logic [VALUE_BITS-1:0] rem_in;
   logic [VALUE_BITS-1:0] den_ff;
   logic [QUO_BITS-1:0]   quo_ff;
   logic [QUO_BITS-1:0]   quo_in;
   logic [VALUE_BITS-1:0] result_ff;
   logic [VALUE_BITS-1:0] result_in;
   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   trial;
   logic                  fits;
   logic                  sat;
   logic [VALUE_BITS-1:0] mag;
   logic [VALUE_BITS-1:0] neg_mag;

   // One quotient bit per cycle; the dividend shifts out of the top of the quotient register.
   always_comb begin
      shifted = {rem_ff, quo_ff[QUO_BITS-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? trial[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      quo_in  = {quo_ff[QUO_BITS-2:0], fits};
      sat     = |quo_ff[QUO_BITS-1:VALUE_BITS-1];
      mag     = quo_ff[VALUE_BITS-1:0];
      neg_mag = -mag;
      if (sat) begin
         result_in = neg_ff ? VAL_MINNEG : VAL_MAXPOS;
      end else begin
         result_in = neg_ff ? neg_mag : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         fin_ff  <= 1'b0;
         if (ctrl.start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_BITS'(QUO_BITS);
            rem_ff <= '0;
            quo_ff <= {numerator, {FRAC_BITS{1'b0}}};
            den_ff <= denominator;
            neg_ff <= ctrl.negative;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end else if (fin_ff) begin
            result_ff <= result_in;
            done_ff   <= 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = result_ff;

endmodule

[rtl/min_max_normalizing_score_table.sv]
// Top level of the min-max normalising score table: command sequencer, store and registers.
//
// Usage. A command is presented on req_command, req_key and req_value and is taken at a
// clock edge where req_start is high and busy is low. Every command yields exactly one
// result transfer: rsp_valid is high for one cycle with rsp_read_value, rsp_present and
// rsp_zero_range, and the receiver must take it then, as it cannot hold results off.
// Insert, insert-worst, clear and unknown commands keep busy low and answer in the cycle
// after the transfer, so one such command may be given every cycle. A read raises busy
// for one cycle and answers through the registered read port of the score memory and
// then the result register. Normalise walks the whole table one entry at a time through
// the shared divider: an entry that is absent, or any entry when the range is empty,
// passes the issue, load and next steps, and a present entry also the start and divide
// steps; the result is registered from the last entry's next step. The csr_ channel
// writes high_is_good and is always ready; the user must write it only while the block
// is quiet, which the block itself does not enforce. Reset is synchronous: it drops
// every entry, returns the minimum to the most positive and the maximum to the most
// negative value, sets high_is_good and aborts any walk. Stored scores are not cleared.
module min_max_normalizing_score_table
   import mmnst_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int VALUE_BITS  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_start,
   output logic                         busy,
   input  logic [2:0]                   req_command,
   input  logic [KEY_BITS-1:0]          req_key,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   output logic signed [RSP_BITS-1:0]   rsp_read_value,
   output logic                         rsp_present,
   output logic                         rsp_zero_range,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_high_is_good
);

   localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(TABLE_DEPTH - 1);
   localparam logic [VALUE_BITS-1:0] VAL_MAXPOS = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] VAL_MINNEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
   // The worst score when low is good is 1.0, clipped where it does not fit the width.
   localparam logic [VALUE_BITS-1:0] ONE_SAT =
      (VALUE_BITS > FRAC_BITS + 1) ? (VALUE_BITS'(1) << FRAC_BITS) : VAL_MAXPOS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_ISSUE,
      S_LOAD,
      S_START,
      S_DIV,
      S_NEXT
   } state_type;

   state_type                    state_ff, state_in;
   logic                         high_ff;
   logic signed [VALUE_BITS-1:0] max_ff, max_in;
   logic signed [VALUE_BITS-1:0] min_ff, min_in;
   logic [TABLE_DEPTH-1:0]       valid_ff, valid_in;
   logic [ADDR_BITS-1:0]         idx_ff, idx_in;
   logic                         zr_ff, zr_in;
   logic [VALUE_BITS-1:0]        den_ff, den_in;
   logic signed [VALUE_BITS:0]   diff_ff, diff_in;
   logic                         rd_present_ff, rd_present_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]          rsp_value_ff, rsp_value_in;
   logic                         rsp_present_ff, rsp_present_in;
   logic                         rsp_zr_ff, rsp_zr_in;

   // Score memory: one write and one registered read per cycle.
   logic [VALUE_BITS-1:0]        score_store_ff [TABLE_DEPTH];
   logic [VALUE_BITS-1:0]        store_q_ff;
   logic [ADDR_BITS-1:0]         rd_addr;
   logic                         we;
   logic [ADDR_BITS-1:0]         waddr;
   logic [VALUE_BITS-1:0]        wdata;

   logic                         accept;
   logic [ADDR_BITS-1:0]         req_addr;
   logic                         key_ok;
   logic signed [VALUE_BITS-1:0] ins_val;
   logic signed [VALUE_BITS:0]   q_ext;
   logic signed [VALUE_BITS:0]   min_ext;
   logic signed [VALUE_BITS:0]   max_ext;
   logic [VALUE_BITS:0]          diff_neg;
   logic [VALUE_BITS-1:0]        numerator;
   div_ctrl_type                 div_ctrl;
   logic                         div_done;
   logic [VALUE_BITS-1:0]        div_quotient;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = req_start && !busy;
   assign csr_ready = 1'b1;
   assign req_addr  = ADDR_BITS'(req_key);
   // A key beyond the table never stores or reads, though an insert still moves min and max.
   assign key_ok    = int'(req_key) < TABLE_DEPTH;
   assign ins_val   = (req_command == CMD_INSERT) ? req_value : (high_ff ? '0 : ONE_SAT);

   assign q_ext     = {store_q_ff[VALUE_BITS-1], store_q_ff};
   assign min_ext   = {min_ff[VALUE_BITS-1], min_ff};
   assign max_ext   = {max_ff[VALUE_BITS-1], max_ff};
   // The divider works on the magnitude; the sign travels with the start request.
   assign diff_neg  = -diff_ff;
   assign numerator = diff_ff[VALUE_BITS] ? diff_neg[VALUE_BITS-1:0] : diff_ff[VALUE_BITS-1:0];

   mmnst_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (div_ctrl),
      .numerator   (numerator),
      .denominator (den_ff),
      .done        (div_done),
      .quotient    (div_quotient)
   );

   always_comb begin
      state_in       = state_ff;
      max_in         = max_ff;
      min_in         = min_ff;
      valid_in       = valid_ff;
      idx_in         = idx_ff;
      zr_in          = zr_ff;
      den_in         = den_ff;
      diff_in        = diff_ff;
      rd_present_in  = rd_present_ff;
      rsp_valid_in   = 1'b0;
      rsp_value_in   = '0;
      rsp_present_in = 1'b0;
      rsp_zr_in      = 1'b0;
      rd_addr        = idx_ff;
      we             = 1'b0;
      waddr          = idx_ff;
      wdata          = '0;
      div_ctrl       = '0;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = req_addr;
            if (accept) begin
               unique case (req_command) inside
                  CMD_INSERT, CMD_INSERT_WORST: begin
                     rsp_valid_in = 1'b1;
                     if (key_ok) begin
                        we                 = 1'b1;
                        waddr              = req_addr;
                        wdata              = ins_val;
                        valid_in[req_addr] = 1'b1;
                     end
                     // Ties update too, which changes nothing.
                     if (ins_val >= max_ff) begin
                        max_in = ins_val;
                     end
                     if (ins_val <= min_ff) begin
                        min_in = ins_val;
                     end
                  end
                  CMD_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     valid_in     = '0;
                  end
                  CMD_NORMALIZE: begin
                     idx_in   = '0;
                     zr_in    = (max_ff <= min_ff);
                     den_in   = VALUE_BITS'(max_ff - min_ff);
                     state_in = S_ISSUE;
                  end
                  CMD_READ: begin
                     rd_present_in = key_ok && valid_ff[req_addr];
                     state_in      = S_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in   = 1'b1;
            rsp_value_in   = rd_present_ff ? RSP_BITS'(store_q_ff) : '0;
            rsp_present_in = rd_present_ff;
            state_in       = S_IDLE;
         end
         S_ISSUE: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (!valid_ff[idx_ff]) begin
               state_in = S_NEXT;
            end else if (zr_ff) begin
               we       = 1'b1;
               state_in = S_NEXT;
            end else begin
               diff_in  = high_ff ? (q_ext - min_ext) : (max_ext - q_ext);
               state_in = S_START;
            end
         end
         S_START: begin
            div_ctrl.start    = 1'b1;
            div_ctrl.negative = diff_ff[VALUE_BITS];
            state_in          = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               we       = 1'b1;
               wdata    = div_quotient;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (idx_ff == LAST_ADDR) begin
               rsp_valid_in = 1'b1;
               rsp_zr_in    = zr_ff;
               state_in     = S_IDLE;
            end else begin
               idx_in   = idx_ff + ADDR_BITS'(1);
               state_in = S_ISSUE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         high_ff      <= 1'b1;
         max_ff       <= VAL_MINNEG;
         min_ff       <= VAL_MAXPOS;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            high_ff <= csr_high_is_good;
         end
      end
      idx_ff         <= idx_in;
      zr_ff          <= zr_in;
      den_ff         <= den_in;
      diff_ff        <= diff_in;
      rd_present_ff  <= rd_present_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_present_ff <= rsp_present_in;
      rsp_zr_ff      <= rsp_zr_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         score_store_ff[waddr] <= wdata;
      end
      store_q_ff <= score_store_ff[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_zero_range = rsp_zr_ff;

   // A result is only ever shown once the sequencer has gone back to idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result shown while the sequencer is busy");

   // The flags only ever accompany a result transfer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_present || rsp_zero_range) |-> rsp_valid)
      else $error("result flag raised without a result strobe");

   // The divider only finishes while the walk is waiting for it.
   assert property (@(posedge clock) disable iff (reset) div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide step");

   // A read holds off further commands for its memory access.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_READ)) |=> busy)
      else $error("read accepted without raising busy");

endmodule
